// ===== rtl/pproj_pkg.sv =====
`timescale 1ns / 1ps

package pproj_pkg;

   localparam int CoordW  = 32;               // q16.16 coordinate
   localparam int DiffW   = CoordW + 1;       // exact difference of two coordinates
   localparam int ProdW   = 2 * DiffW;        // product of two differences
   localparam int DotW    = ProdW + 2;        // signed sum of three products
   localparam int MagW    = ProdW;            // magnitude of dot and of squared length
   localparam int FracW   = 16;               // fraction bits
   localparam int QuotW   = CoordW;           // quotient bits resolved by the divider
   localparam int RemW    = MagW + 1;
   localparam int MulW    = CoordW + DiffW - 1;  // |n| * |d| fits in 64 bits
   localparam int SumW    = MulW - FracW + 2;    // a +/- rounded offset
   localparam int Axes    = 3;

   typedef struct packed {
      logic [Axes-1:0][CoordW-1:0] a;
      logic [Axes-1:0][DiffW-1:0]  dmag;
      logic [Axes-1:0]             dneg;
      logic                        zero;
      logic                        neg;
   } side_type;

   function automatic logic [CoordW-1:0] sat_coord(input logic signed [SumW-1:0] s);
      logic signed [SumW-1:0] hi;
      logic signed [SumW-1:0] lo;
      hi = SumW'((64'sd1 <<< (CoordW - 1)) - 64'sd1);
      lo = -SumW'(64'sd1 <<< (CoordW - 1));
      if (s > hi) begin
         return hi[CoordW-1:0];
      end else if (s < lo) begin
         return lo[CoordW-1:0];
      end
      return s[CoordW-1:0];
   endfunction

endpackage

// ===== rtl/point_to_line_projection.sv =====
`timescale 1ns / 1ps

// projects point p onto the line through a and b, all signed q16.16. with d = b - a and
// v = p - a the block forms v.d and d.d exactly, divides once for n = v.d / d.d (rounded
// half away from zero, saturated), and returns a + n*d per axis, rounded and saturated.
// a == b gives a result with valid_res low and all other fields zero. one transaction
// enters per cycle; the path from input to output register holds four stages of
// difference, multiply, sum and magnitude, one divider entry stage, 32 one-bit divider
// stages, one rounding stage, and three stages for the final multiply, add and clamp.
// the whole pipeline holds when the output register is full and not taken.
module point_to_line_projection (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // line_a_x, line_a_y, line_a_z, line_b_x, line_b_y, line_b_z, point_x, point_y, point_z
   input  logic [287:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // coefficient, proj_x, proj_y, proj_z
   output logic [127:0] rsp_tdata,
   // valid_res
   output logic         rsp_tuser
);

   localparam int CW = pproj_pkg::CoordW;
   localparam int AX = pproj_pkg::Axes;

   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // stage 1: differences
   logic                                  s1_v_ff;
   logic signed [CW-1:0]                  a1_ff [AX];
   logic signed [pproj_pkg::DiffW-1:0]    d1_ff [AX];
   logic signed [pproj_pkg::DiffW-1:0]    v1_ff [AX];

   // stage 2: products
   logic                                  s2_v_ff;
   logic signed [pproj_pkg::ProdW-1:0]    pvd_ff [AX];
   logic signed [pproj_pkg::ProdW-1:0]    pdd_ff [AX];
   pproj_pkg::side_type                   side2_ff;

   // stage 3: sums
   logic                                  s3_v_ff;
   logic signed [pproj_pkg::DotW-1:0]     dot_ff;
   logic [pproj_pkg::MagW-1:0]            den_ff;
   pproj_pkg::side_type                   side3_ff;

   // stage 4: magnitude of the dot product
   logic                                  s4_v_ff;
   logic [pproj_pkg::MagW-1:0]            mag4_ff;
   logic [pproj_pkg::MagW-1:0]            den4_ff;
   pproj_pkg::side_type                   side4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_tvalid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < AX; i++) begin
            a1_ff[i] <= req_tdata[i*CW +: CW];
            d1_ff[i] <= pproj_pkg::DiffW'($signed(req_tdata[(AX+i)*CW +: CW]))
                      - pproj_pkg::DiffW'($signed(req_tdata[i*CW +: CW]));
            v1_ff[i] <= pproj_pkg::DiffW'($signed(req_tdata[(2*AX+i)*CW +: CW]))
                      - pproj_pkg::DiffW'($signed(req_tdata[i*CW +: CW]));
         end
      end
   end

   pproj_pkg::side_type side1;
   always_comb begin
      side1      = '0;
      for (int i = 0; i < AX; i++) begin
         side1.a[i]    = a1_ff[i];
         side1.dneg[i] = d1_ff[i][pproj_pkg::DiffW-1];
         side1.dmag[i] = d1_ff[i][pproj_pkg::DiffW-1] ? -d1_ff[i] : d1_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < AX; i++) begin
            pvd_ff[i] <= v1_ff[i] * d1_ff[i];
            pdd_ff[i] <= d1_ff[i] * d1_ff[i];
         end
         side2_ff <= side1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dot_ff   <= pproj_pkg::DotW'(pvd_ff[0]) + pproj_pkg::DotW'(pvd_ff[1])
                   + pproj_pkg::DotW'(pvd_ff[2]);
         den_ff   <= pproj_pkg::MagW'(pdd_ff[0][pproj_pkg::ProdW-2:0])
                   + pproj_pkg::MagW'(pdd_ff[1][pproj_pkg::ProdW-2:0])
                   + pproj_pkg::MagW'(pdd_ff[2][pproj_pkg::ProdW-2:0]);
         side3_ff <= side2_ff;
      end
   end

   logic signed [pproj_pkg::DotW-1:0] dot_abs;
   pproj_pkg::side_type               side3_upd;
   assign dot_abs = dot_ff[pproj_pkg::DotW-1] ? -dot_ff : dot_ff;
   always_comb begin
      side3_upd      = side3_ff;
      side3_upd.neg  = dot_ff[pproj_pkg::DotW-1];
      side3_upd.zero = (den_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag4_ff  <= dot_abs[pproj_pkg::MagW-1:0];
         den4_ff  <= den_ff;
         side4_ff <= side3_upd;
      end
   end

   // divider
   logic                 dv_v;
   logic [CW-1:0]        dv_nmag;
   pproj_pkg::side_type  dv_side;

   pproj_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s4_v_ff),
      .in_mag    (mag4_ff),
      .in_den    (den4_ff),
      .in_side   (side4_ff),
      .out_valid (dv_v),
      .out_nmag  (dv_nmag),
      .out_side  (dv_side)
   );

   // placement: |n|*|d|, then a +/- rounded offset, then clamp
   logic                                 p1_v_ff;
   logic [pproj_pkg::MulW-1:0]           m_ff    [AX];
   logic [AX-1:0]                        sgn_ff;
   logic [CW-1:0]                        coef1_ff;
   logic [AX-1:0][CW-1:0]                a_p1_ff;
   logic                                 zero1_ff;

   logic                                 p2_v_ff;
   logic signed [pproj_pkg::SumW-1:0]    sum_ff  [AX];
   logic [CW-1:0]                        coef2_ff;
   logic                                 zero2_ff;

   logic                                 out_v_ff;
   logic [127:0]                         out_data_ff;
   logic                                 out_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff  <= 1'b0;
         p2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         p1_v_ff  <= dv_v;
         p2_v_ff  <= p1_v_ff;
         out_v_ff <= p2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < AX; i++) begin
            m_ff[i]   <= pproj_pkg::MulW'(dv_nmag) * pproj_pkg::MulW'(dv_side.dmag[i]);
            sgn_ff[i] <= dv_side.neg ^ dv_side.dneg[i];
         end
         coef1_ff <= dv_side.neg ? -dv_nmag : dv_nmag;
         a_p1_ff  <= dv_side.a;
         zero1_ff <= dv_side.zero;
      end
   end

   logic [pproj_pkg::MulW-1:0]        rnd_m   [AX];
   logic signed [pproj_pkg::SumW-1:0] offset  [AX];
   always_comb begin
      for (int i = 0; i < AX; i++) begin
         rnd_m[i]  = (m_ff[i] + (pproj_pkg::MulW'(1) << (pproj_pkg::FracW - 1)))
                   >> pproj_pkg::FracW;
         offset[i] = sgn_ff[i] ? -pproj_pkg::SumW'(rnd_m[i])
                               :  pproj_pkg::SumW'(rnd_m[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < AX; i++) begin
            sum_ff[i] <= pproj_pkg::SumW'($signed(a_p1_ff[i])) + offset[i];
         end
         coef2_ff <= coef1_ff;
         zero2_ff <= zero1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (zero2_ff) begin
            out_data_ff <= '0;
         end else begin
            out_data_ff <= {pproj_pkg::sat_coord(sum_ff[2]),
                            pproj_pkg::sat_coord(sum_ff[1]),
                            pproj_pkg::sat_coord(sum_ff[0]),
                            coef2_ff};
         end
         out_user_ff <= !zero2_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   // a degenerate line gives an all-zero transaction
   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("degenerate line result not zero");

   // the input is held back only by a full, untaken output register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output back-pressure");

   // a positive coefficient never exceeds the q16.16 maximum
   a_coef_clamp: assert property (@(posedge clock) disable iff (reset)
      dv_v && !dv_side.neg |-> !dv_nmag[CW-1])
      else $error("positive coefficient above range");

endmodule

// ===== rtl/pproj_div.sv =====
`timescale 1ns / 1ps

// restoring divider, one quotient bit per stage, with overflow check and rounding
module pproj_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic [pproj_pkg::MagW-1:0]          in_mag,
   input  logic [pproj_pkg::MagW-1:0]          in_den,
   input  pproj_pkg::side_type                 in_side,
   output logic                                out_valid,
   output logic [pproj_pkg::CoordW-1:0]        out_nmag,
   output pproj_pkg::side_type                 out_side
);

   localparam int N = pproj_pkg::QuotW;

   logic                             v_ff    [0:N];
   logic [pproj_pkg::RemW-1:0]       rem_ff  [0:N];
   logic [N-1:0]                     q_ff    [0:N];
   logic [N-1:0]                     low_ff  [0:N];
   logic [pproj_pkg::MagW-1:0]       den_ff  [0:N];
   logic                             ovf_ff  [0:N];
   pproj_pkg::side_type              side_ff [0:N];

   logic                             nv_ff;
   logic [pproj_pkg::CoordW-1:0]     nmag_ff;
   pproj_pkg::side_type              nside_ff;

   logic [pproj_pkg::MagW-1:0]       hi_part;
   assign hi_part = pproj_pkg::MagW'(in_mag[pproj_pkg::MagW-1:pproj_pkg::FracW]);

   // entry: quotient of 2^32 or more saturates, else the high part is the first remainder
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= pproj_pkg::RemW'(hi_part);
         q_ff[0]    <= '0;
         low_ff[0]  <= {in_mag[pproj_pkg::FracW-1:0], {(N - pproj_pkg::FracW){1'b0}}};
         den_ff[0]  <= in_den;
         ovf_ff[0]  <= (hi_part >= in_den);
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [pproj_pkg::RemW-1:0] trial;
      logic                       ge;
      assign trial = {rem_ff[k][pproj_pkg::RemW-2:0], low_ff[k][N-1]};
      assign ge    = (trial >= {1'b0, den_ff[k]});

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= ge ? (trial - {1'b0, den_ff[k]}) : trial;
            q_ff[k+1]    <= {q_ff[k][N-2:0], ge};
            low_ff[k+1]  <= {low_ff[k][N-2:0], 1'b0};
            den_ff[k+1]  <= den_ff[k];
            ovf_ff[k+1]  <= ovf_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   // round half away from zero, then clamp to the signed q16.16 range
   logic           rnd;
   logic [N:0]     q_rnd;
   logic [N:0]     lim;
   assign rnd   = ({rem_ff[N], 1'b0} >= {2'b00, den_ff[N]});
   assign q_rnd = {1'b0, q_ff[N]} + (N+1)'(rnd);
   assign lim   = side_ff[N].neg ? ((N+1)'(1) << (N - 1)) : (((N+1)'(1) << (N - 1)) - 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         nv_ff <= 1'b0;
      end else if (en) begin
         nv_ff <= v_ff[N];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nmag_ff  <= (ovf_ff[N] || (q_rnd > lim)) ? lim[N-1:0] : q_rnd[N-1:0];
         nside_ff <= side_ff[N];
      end
   end

   assign out_valid = nv_ff;
   assign out_nmag  = nmag_ff;
   assign out_side  = nside_ff;

endmodule
